// File: design/lpht_pkg.sv
package lpht_pkg;

  // Table geometry.
  localparam int TABLE_SIZE = 16;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  // Field widths of the two channels.
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;

  // Reciprocal of the table size for the home-slot reduction.
  // floor(key * RECIP / 2^RECIP_W) is the true quotient or one less.
  localparam int RECIP_W = 32;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_W) / TABLE_SIZE);

  // Commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  // Result codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISSING  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // Slot tags.
  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_USED  = 2'd1,
    TAG_GONE  = 2'd2
  } tag_e;

  typedef logic [IDX_W-1:0] idx_t;

  // One table entry: tag and key.
  typedef struct packed {
    tag_e             tag;
    logic [KEY_W-1:0] key;
  } entry_t;

  // Memory request from the probe sequencer to the slot store.
  typedef struct packed {
    logic   rd_en;
    idx_t   rd_addr;
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
  } mem_req_t;

  // Finished result handed to the output stage.
  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
  } res_t;

  // Low SLOT_W bits of a slot index, zero-extended when the index is narrower.
  function automatic logic [SLOT_W-1:0] slot_of(idx_t idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

// File: design/lpht_store.sv
module lpht_store import lpht_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output entry_t   rd_data_o
);

  // Slot memory: one write and one read port, registered read data.
  entry_t mem_q [TABLE_SIZE];
  entry_t rd_data_q;

  // One valid bit per slot; a slot never written reads as empty.
  logic [TABLE_SIZE-1:0] vld_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  // Entries that were never written look empty with key zero.
  assign rd_data_o = rd_vld_q ? rd_data_q : entry_t'{tag: TAG_EMPTY, key: '0};

  // A written slot is marked valid on the following cycle.
  a_wr_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.wr_en |=> vld_q[$past(req_i.wr_addr)])
    else $error("written slot not marked valid");

  // The sequencer never reads and writes the store in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.wr_en && req_i.rd_en))
    else $error("read and write in the same cycle");

  // Reset leaves every slot empty.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> vld_q == '0)
    else $error("valid bits not cleared by reset");

endmodule

// File: design/lpht_probe.sv
module lpht_probe import lpht_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CMD_W-1:0] command_i,
  input  logic [KEY_W-1:0] key_i,
  output mem_req_t         mem_req_o,
  input  entry_t           rd_data_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_HOME,
    S_PROBE,
    S_HOLD
  } state_e;

  state_e           state_q;
  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] quot_q;
  idx_t             addr_q;
  idx_t             cnt_q;
  res_t             res_q;

  logic [KEY_W+RECIP_W-1:0] prod;
  logic [2*KEY_W-1:0]       qd;
  logic [KEY_W-1:0]         rem_raw;
  logic [KEY_W-1:0]         rem;
  idx_t                     home;
  idx_t                     next_addr;
  logic                     cmd_ok;
  logic                     is_insert;
  logic                     take;
  logic                     hit;
  logic                     miss;
  logic                     last;
  logic                     finish;

  // Home slot: quotient estimate from the reciprocal, then one correction.
  assign prod    = (KEY_W+RECIP_W)'(key_q) * (KEY_W+RECIP_W)'(RECIP);
  assign qd      = (2*KEY_W)'(quot_q) * (2*KEY_W)'(TABLE_SIZE);
  assign rem_raw = key_q - qd[KEY_W-1:0];
  assign rem     = (rem_raw >= KEY_W'(TABLE_SIZE)) ? rem_raw - KEY_W'(TABLE_SIZE) : rem_raw;
  assign home    = rem[IDX_W-1:0];

  assign cmd_ok    = (cmd_q == CMD_INSERT) || (cmd_q == CMD_DELETE) || (cmd_q == CMD_SEARCH);
  assign is_insert = (cmd_q == CMD_INSERT);

  // Decision on the slot just read.
  assign take      = is_insert && (rd_data_i.tag != TAG_USED);
  assign hit       = !is_insert && (rd_data_i.tag == TAG_USED) && (rd_data_i.key == key_q);
  assign miss      = !is_insert && (rd_data_i.tag == TAG_EMPTY);
  assign last      = (cnt_q == IDX_W'(TABLE_SIZE - 1));
  assign finish    = take || hit || miss || last;
  assign next_addr = (addr_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : addr_q + idx_t'(1);

  // Memory requests: one read per probe step, a write on the final step of an insert or delete.
  always_comb begin
    mem_req_o = '0;
    unique case (state_q)
      S_HOME: begin
        if (cmd_ok) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = home;
        end
      end
      S_PROBE: begin
        if (take) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = addr_q;
          mem_req_o.wr_data = '{tag: TAG_USED, key: key_q};
        end else if (hit && (cmd_q == CMD_DELETE)) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = addr_q;
          mem_req_o.wr_data = '{tag: TAG_GONE, key: rd_data_i.key};
        end else if (!finish) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = next_addr;
        end
      end
      S_IDLE, S_MUL, S_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and the finished result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      key_q   <= '0;
      quot_q  <= '0;
      addr_q  <= '0;
      cnt_q   <= '0;
      res_q   <= '{status: ST_MISSING, slot: '0};
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= command_i;
            key_q   <= key_i;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          quot_q  <= prod[KEY_W+RECIP_W-1:RECIP_W];
          state_q <= S_HOME;
        end
        S_HOME: begin
          addr_q <= home;
          cnt_q  <= '0;
          if (cmd_ok) begin
            state_q <= S_PROBE;
          end else begin
            res_q   <= '{status: ST_MISSING, slot: '0};
            state_q <= S_HOLD;
          end
        end
        S_PROBE: begin
          if (take) begin
            res_q   <= '{status: ST_INSERTED, slot: slot_of(addr_q)};
            state_q <= S_HOLD;
          end else if (hit) begin
            res_q   <= '{status: (cmd_q == CMD_DELETE) ? ST_DELETED : ST_FOUND,
                         slot: slot_of(addr_q)};
            state_q <= S_HOLD;
          end else if (miss || last) begin
            res_q   <= '{status: is_insert ? ST_FULL : ST_MISSING, slot: '0};
            state_q <= S_HOLD;
          end else begin
            addr_q <= next_addr;
            cnt_q  <= cnt_q + idx_t'(1);
          end
        end
        S_HOLD: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_HOLD);
  assign res_o       = res_q;

  // An accepted beat starts the home-slot computation.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_MUL)
    else $error("accepted beat did not start a probe");

  // A table write always ends the probe sequence.
  a_write_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |=> state_q == S_HOLD)
    else $error("probe continued after a write");

  // The probe counter never passes the table size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROBE && !finish |=> cnt_q != '0)
    else $error("probe counter wrapped");

endmodule

// File: design/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing over TABLE_SIZE slots.
// Input channel: in_valid_i / in_stall_o carry one beat of command_i
// (insert, delete, search) and key_i. Output channel: out_valid_o /
// out_stall_i carry one beat of status_o and slot_o per input beat.
// A beat moves on a rising edge with valid high and stall low.
// Sequence: after an input beat is accepted, the key is reduced to its home
// slot (S_MUL, S_HOME), then the slot store is read one slot per cycle
// until the probe ends (S_PROBE), and the result is held for the output
// register (S_HOLD). An unused command skips the probe and gives ST_MISSING.
// The sequencer takes no new beat until it has handed its result over; the
// probe loop and the single read port on the slot store set this pace.
// The output register lets the next beat be taken while a result waits.
// If out_stall_i holds the output register full when the next result is
// ready, the sequencer waits and keeps in_stall_o high until it drains.
// Reset clears every slot to empty at once and empties the output register.
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [KEY_W-1:0]    key_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   slot_o
);

  mem_req_t mem_req;
  entry_t   rd_data;
  logic     res_valid;
  logic     res_ready;
  res_t     res;

  logic                out_valid_q;
  logic                out_valid_d;
  logic [STATUS_W-1:0] status_q;
  logic [SLOT_W-1:0]   slot_q;

  lpht_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  lpht_probe u_probe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .key_i       (key_i),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: loads when empty or being drained this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      status_q <= res.status;
      slot_q   <= res.slot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;

  // A result handed over is always captured by the output register.
  a_res_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |=> out_valid_o)
    else $error("handed result not captured");

  // Slot is zero whenever the status reports no slot.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_MISSING || status_o == ST_FULL) |-> slot_o == '0)
    else $error("slot set on a miss or full result");

  // The block never accepts a new beat while a result is still being formed.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_stall_o)
    else $error("input accepted while a result is pending");

endmodule

// File: tb/sv/linear_probe_hash_table_tb.sv
module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  // Command code that the block answers without touching the table.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int NUM_DIRECTED = 28;
  localparam int RANDOM_ITEMS = 1120;
  localparam int POOL_SIZE    = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 500000;

  // One row of the directed stimulus; fixed rows carry their own answer.
  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    bit               fixed;
    status_e          status;
    logic [SLOT_W-1:0] slot;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    command;
  logic [KEY_W-1:0]    key;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  // Shadow copy of the slot store.
  tag_e             model_tag [TABLE_SIZE];
  logic [KEY_W-1:0] model_key [TABLE_SIZE];

  res_t pending_results [$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  bit   rx_hold_req = 1'b0;
  bit   rx_idle_on = 1'b1;

  stim_row_t directed [NUM_DIRECTED] = '{
    '{CMD_SEARCH, 16'h0000, 1'b1, ST_MISSING,  4'd0},
    '{CMD_DELETE, 16'hFFFF, 1'b1, ST_MISSING,  4'd0},
    '{CMD_UNUSED, 16'hA5A5, 1'b1, ST_MISSING,  4'd0},
    '{CMD_INSERT, 16'h0000, 1'b1, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'hFFFF, 1'b1, ST_INSERTED, 4'd15},
    '{CMD_INSERT, 16'h0010, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_SEARCH, 16'h0010, 1'b0, ST_MISSING,  4'd0},
    '{CMD_SEARCH, 16'hFFFF, 1'b1, ST_FOUND,    4'd15},
    '{CMD_DELETE, 16'h0000, 1'b1, ST_DELETED,  4'd0},
    '{CMD_SEARCH, 16'h0010, 1'b0, ST_MISSING,  4'd0},
    '{CMD_SEARCH, 16'h0000, 1'b1, ST_MISSING,  4'd0},
    '{CMD_INSERT, 16'h0020, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h5555, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h5555, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h5555, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h5555, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h5555, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h5555, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h5555, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h5555, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h5555, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h5555, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h5555, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h5555, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h5555, 1'b0, ST_INSERTED, 4'd0},
    '{CMD_INSERT, 16'h1234, 1'b1, ST_FULL,     4'd0},
    '{CMD_SEARCH, 16'h0007, 1'b1, ST_MISSING,  4'd0},
    '{CMD_DELETE, 16'h5555, 1'b0, ST_INSERTED, 4'd0}
  };

  linear_probe_hash_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .key_i       (key),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .slot_o      (slot)
  );

  // Clock with a period of two time units.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Applies one command to the shadow table and returns the answer it gives.
  function automatic res_t table_apply(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k);
    res_t answer;
    int   probe;
    int   n;
    bit   done;
    answer.status = ST_MISSING;
    answer.slot   = '0;
    probe = int'(k) % TABLE_SIZE;
    done  = 1'b0;
    if (cmd == CMD_INSERT) begin
      answer.status = ST_FULL;
      for (n = 0; n < TABLE_SIZE && !done; n++) begin
        if (model_tag[probe] != TAG_USED) begin
          model_tag[probe] = TAG_USED;
          model_key[probe] = k;
          answer.status = ST_INSERTED;
          answer.slot   = SLOT_W'(probe);
          done = 1'b1;
        end else begin
          probe = (probe == TABLE_SIZE - 1) ? 0 : probe + 1;
        end
      end
    end else if (cmd == CMD_DELETE || cmd == CMD_SEARCH) begin
      // Probe stops at an empty slot, at the first live match, or after one pass.
      for (n = 0; n < TABLE_SIZE && !done; n++) begin
        if (model_tag[probe] == TAG_EMPTY) begin
          done = 1'b1;
        end else if (model_tag[probe] == TAG_USED && model_key[probe] == k) begin
          answer.status = (cmd == CMD_DELETE) ? ST_DELETED : ST_FOUND;
          answer.slot   = SLOT_W'(probe);
          if (cmd == CMD_DELETE) begin
            model_tag[probe] = TAG_GONE;
          end
          done = 1'b1;
        end else begin
          probe = (probe == TABLE_SIZE - 1) ? 0 : probe + 1;
        end
      end
    end
    return answer;
  endfunction

  // Offers one input beat after an idle gap and records its answer on acceptance.
  task automatic offer_beat(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                            input int gap, input bit fixed, input res_t fixed_res);
    res_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    key      <= k;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = table_apply(cmd, k);
    pending_results.push_back(fixed ? fixed_res : predicted);
  endtask

  // Sender: reset, directed rows, then random traffic.
  initial begin
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] k;
    res_t             fixed_res;
    bit               tx_idle_on;
    bit               filling;
    int               gap;
    int               pick;
    int               ins_pct;
    int               del_pct;
    int               hold_at;
    int               pause_at;
    in_valid <= 1'b0;
    command  <= CMD_INSERT;
    key      <= '0;
    rst_n = 1'b0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      model_tag[i] = TAG_EMPTY;
      model_key[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = KEY_W'($urandom);
    end
    hold_at  = $urandom_range(300, 500);
    pause_at = $urandom_range(700, 900);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      fixed_res.status = directed[r].status;
      fixed_res.slot   = directed[r].slot;
      offer_beat(directed[r].cmd, directed[r].key, $urandom_range(0, 7),
                 directed[r].fixed, fixed_res);
    end

    // Random traffic in alternating fill and drain phases.
    tx_idle_on = 1'b1;
    filling    = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        filling = ~filling;
      end
      if (i % 64 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (i == hold_at) begin
        rx_hold_req = 1'b1;
      end
      // Let the block drain completely once before going on.
      if (i == pause_at) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      ins_pct = filling ? 58 : 23;
      del_pct = filling ? 20 : 50;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        cmd = CMD_UNUSED;
      end else if (pick < ins_pct) begin
        cmd = CMD_INSERT;
      end else if (pick < ins_pct + del_pct) begin
        cmd = CMD_DELETE;
      end else begin
        cmd = CMD_SEARCH;
      end
      if ($urandom_range(0, 19) == 0) begin
        key_pool[$urandom_range(0, POOL_SIZE - 1)] = KEY_W'($urandom);
      end
      if ($urandom_range(0, 99) < 15) begin
        k = KEY_W'($urandom_range(0, 65535));
      end else begin
        k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      gap = tx_idle_on ? $urandom_range(0, 7) : 0;
      offer_beat(cmd, k, gap, 1'b0, fixed_res);
    end
    in_valid <= 1'b0;

    // Wait for every answer, then watch for stray beats.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: random stall before each beat, and one long hold-off.
  initial begin
    int wait_cycles;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      wait_cycles = rx_idle_on ? $urandom_range(0, 7) : 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  // Compare each accepted result beat with the oldest answer waiting.
  always @(posedge clk) begin
    res_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding: status %0d slot %0d",
               status, slot);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatch_count++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
